[design/spq_pkg.sv]
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_cmd_t;

  localparam entry_t ENTRY_EMPTY = '{valid: 1'b0, value: '0, prio: '0};

endpackage

[design/spq_cell.sv]
module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t    new_ent,
  input  spq_pkg::entry_t    prev_ent,
  input  logic               prev_take,
  input  spq_pkg::entry_t    next_ent,
  output spq_pkg::entry_t    ent,
  output logic               take
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // new entry lands behind every held entry of greater or equal priority
  assign take = !ent_r.valid || ($signed(ent_r.prio) < $signed(new_ent.prio));
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.enq && take) begin
      ent_nxt = prev_take ? prev_ent : new_ent;
    end else if (cmd.deq) begin
      ent_nxt = next_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.value <= ent_nxt.value;
    ent_r.prio  <= ent_nxt.prio;
  end

endmodule

[design/sorted_priority_queue.sv]
// Sorted priority queue: a row of CAPACITY cells kept in descending priority
// order, cell 0 at the head; equal priorities leave first in, first out.
// Each input beat is one operation (enqueue, dequeue, peek) and yields one
// result beat, registered the cycle after acceptance. One operation is taken
// every cycle while results are taken; the cycle is set by the priority
// compare that every cell makes against the incoming entry in parallel and
// the one-step shift to the neighbor cell. Reset empties the queue at once.
module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic signed [31:0] in_item_value,
  input  logic signed [31:0] in_item_priority,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_head_value,
  output logic signed [31:0] out_head_priority,
  output logic [4:0]         out_occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t            ent  [CAPACITY];
  logic [CAPACITY-1:0] take;
  logic [CAPACITY-1:0] ent_valid;
  entry_t            new_ent;
  cell_cmd_t         cmd;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r;
  logic [1:0]        status_r, status_nxt;
  logic signed [31:0] hv_r, hv_nxt, hp_r, hp_nxt;
  logic [OCC_W-1:0]  occ_r;

  logic accept, full, empty;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);

  assign new_ent = '{valid: 1'b1, value: in_item_value, prio: in_item_priority};

  assign cmd.enq = accept && (in_operation == OP_ENQUEUE) && !full;
  assign cmd.deq = accept && (in_operation == OP_DEQUEUE) && !empty;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      entry_t prev_ent, next_ent;
      logic   prev_take;
      if (i == 0) begin : g_head
        assign prev_ent  = new_ent;
        assign prev_take = 1'b0;
      end else begin : g_body
        assign prev_ent  = ent[i-1];
        assign prev_take = take[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign next_ent = ENTRY_EMPTY;
      end else begin : g_mid
        assign next_ent = ent[i+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .new_ent   (new_ent),
        .prev_ent  (prev_ent),
        .prev_take (prev_take),
        .next_ent  (next_ent),
        .ent       (ent[i]),
        .take      (take[i])
      );
      assign ent_valid[i] = ent[i].valid;
    end
  endgenerate

  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    hv_nxt     = '0;
    hp_nxt     = '0;
    case (in_operation)
      OP_ENQUEUE: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_DEQUEUE, OP_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          hv_nxt = ent[0].value;
          hp_nxt = ent[0].prio;
          if (in_operation == OP_DEQUEUE) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      status_r <= status_nxt;
      hv_r     <= hv_nxt;
      hp_r     <= hp_nxt;
      occ_r    <= OCC_W'(cnt_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_value    = hv_r;
  assign out_head_priority = hp_r;
  assign out_occupancy     = occ_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_cnt_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ent_valid) == int'(cnt_r))
    else $error("cell valid bits disagree with entry count");

  a_deq_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.deq |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("dequeue did not remove one entry");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_operation == OP_ENQUEUE) && full |=> out_status == ST_FULL && $stable(cnt_r))
    else $error("enqueue into full queue changed the store");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_EMPTY) |-> hv_r == '0 && hp_r == '0)
    else $error("empty result carries nonzero head");
`endif

endmodule
